// ===== sv/lcl_pkg.sv =====
// Shared types, codes and helpers for the LRU cache lookup block.
package lcl_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int CMD_W     = 2;
    localparam int OUT_W     = 2;
    localparam int SETB_W    = 3;
    localparam int BLKB_W    = 5;
    localparam int WAYSR_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int RAW_SET_W = 7;
    localparam int RAW_SET_N = 1 << RAW_SET_W;
    localparam int SPLIT_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_FETCH  = 2'd3
    } t_cmd;

    typedef enum logic [OUT_W-1:0] {
        OUT_IGNORED = 2'd0,
        OUT_HIT     = 2'd1,
        OUT_MISS    = 2'd2,
        OUT_EVICT   = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2,
        CFG_NONE       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT
    } t_state;

    typedef struct packed {
        logic               vld;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    localparam int LINE_W = $bits(t_line);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

// ===== sv/lcl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/lcl_addr_split.sv =====
// Address split into set index and in-place tag from the configured bit counts.
module lcl_addr_split
    import lcl_pkg::*;
#(
    parameter int MAX_SETS = 64
) (
    input  logic [ADDR_W-1:0]                          i_address,
    input  logic [SETB_W-1:0]                          i_set_bits,
    input  logic [BLKB_W-1:0]                          i_block_bits,
    output logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] o_set,
    output logic [TAG_W-1:0]                           o_tag
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    logic [SET_W-1:0]     mod_tbl [RAW_SET_N];
    logic [ADDR_W-1:0]    w_shifted;
    logic [RAW_SET_W-1:0] w_raw;
    logic [SPLIT_W-1:0]   w_split;

    for (genvar k = 0; k < RAW_SET_N; k++) begin : g_mod
        assign mod_tbl[k] = SET_W'(k % MAX_SETS);
    end

    assign w_shifted = i_address >> i_block_bits;
    assign w_raw     = w_shifted[RAW_SET_W-1:0] & ~({RAW_SET_W{1'b1}} << i_set_bits);
    assign o_set     = mod_tbl[w_raw];
    assign w_split   = SPLIT_W'(i_block_bits) + SPLIT_W'(i_set_bits);
    assign o_tag     = (w_split >= SPLIT_W'(ADDR_W)) ? '0
                     : (i_address & ({ADDR_W{1'b1}} << w_split[4:0]));

endmodule

// ===== sv/lru_cache_lookup_unit.sv =====
// Top level: set-associative cache lookup with LRU replacement over a set-row RAM.
//
//  channel   | handshake            | words
//  ----------+----------------------+---------------------------------------------
//  access in | start / busy         | i_cmd, i_address
//  result    | o_done (1-cycle)     | o_outcome, o_extra_hit, o_*_total
//  config    | i_cfg_we             | i_cfg_addr, i_cfg_data
//
// Fetch is answered without a RAM read. Hit or fill: RAM row read, then compare and write back.
// Eviction adds a search for the oldest stamp, one way per cycle, before the write-back.
// Result appears the cycle after the write-back; a new word may be taken in that cycle.
// Reset clears all lines through one valid flag per set; no clearing pass.
// Results cannot be stalled.
module lru_cache_lookup_unit
    import lcl_pkg::*;
#(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [ADDR_W-1:0]    i_address,
    output logic                 o_done,
    output logic [OUT_W-1:0]     o_outcome,
    output logic                 o_extra_hit,
    output logic [CNT_W-1:0]     o_hit_total,
    output logic [CNT_W-1:0]     o_miss_total,
    output logic [CNT_W-1:0]     o_eviction_total,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    t_state               r_state, n_state;
    logic [SETB_W-1:0]    r_set_bits;
    logic [BLKB_W-1:0]    r_block_bits;
    logic [WAYSR_W-1:0]   r_ways;
    logic [MAX_SETS-1:0]  r_row_vld;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_modify;
    logic [STAMP_W-1:0]   r_clock, n_clock;
    logic [CNT_W-1:0]     r_hits, n_hits, r_misses, n_misses, r_evicts, n_evicts;
    logic                 r_done, n_done;
    t_outcome             r_outcome, n_outcome;
    logic                 r_extra, n_extra;
    logic [WAY_W-1:0]     r_idx, n_idx, r_victim, n_victim;
    logic [STAMP_W-1:0]   r_best, n_best;

    logic                 w_accept;
    logic [SET_W-1:0]     w_set;
    logic [TAG_W-1:0]     w_tag;
    logic                 w_ram_re, w_ram_we;
    t_line [MAX_WAYS-1:0] w_rdata, w_eff_row, w_wrow;
    logic [WCNT_W-1:0]    w_nw;
    logic                 w_hit, w_free;
    logic [WAY_W-1:0]     w_hit_way, w_free_way;
    logic [STAMP_W-1:0]   w_age;
    logic                 w_fin;
    t_outcome             w_fin_out;

    assign busy     = !i_rst_n || (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_ram_re = w_accept && (t_cmd'(i_cmd) != CMD_FETCH);

    lcl_addr_split #(.MAX_SETS(MAX_SETS)) u_split (
        .i_address    (i_address),
        .i_set_bits   (r_set_bits),
        .i_block_bits (r_block_bits),
        .o_set        (w_set),
        .o_tag        (w_tag)
    );

    lcl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_set),
        .i_wdata (w_wrow),
        .i_re    (w_ram_re),
        .i_raddr (w_set),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_ways == '0) begin
            w_nw = WCNT_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            w_nw = WCNT_W'(MAX_WAYS);
        end else begin
            w_nw = WCNT_W'(r_ways);
        end
    end

    // lines of a set never written since reset read as invalid
    always_comb begin
        w_eff_row  = w_rdata;
        w_hit      = 1'b0;
        w_free     = 1'b0;
        w_hit_way  = '0;
        w_free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_eff_row[w].vld = w_rdata[w].vld && r_row_vld[r_set];
            if (WCNT_W'(w) < w_nw) begin
                if (w_eff_row[w].vld && (w_rdata[w].tag == r_tag) && !w_hit) begin
                    w_hit     = 1'b1;
                    w_hit_way = WAY_W'(w);
                end
                if (!w_eff_row[w].vld && !w_free) begin
                    w_free     = 1'b1;
                    w_free_way = WAY_W'(w);
                end
            end
        end
    end

    assign w_age = r_clock - w_rdata[r_idx].stamp;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_victim  = r_victim;
        n_best    = r_best;
        w_ram_we  = 1'b0;
        w_wrow    = w_eff_row;
        w_fin     = 1'b0;
        w_fin_out = OUT_HIT;
        unique case (r_state)
            S_IDLE: begin
                if (w_ram_re) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_hit) begin
                    w_wrow[w_hit_way].stamp = r_clock;
                    w_ram_we  = 1'b1;
                    w_fin     = 1'b1;
                    w_fin_out = OUT_HIT;
                    n_state   = S_IDLE;
                end else if (w_free) begin
                    w_wrow[w_free_way] = '{vld: 1'b1, tag: r_tag, stamp: r_clock};
                    w_ram_we  = 1'b1;
                    w_fin     = 1'b1;
                    w_fin_out = OUT_MISS;
                    n_state   = S_IDLE;
                end else begin
                    n_victim = '0;
                    n_best   = r_clock - w_rdata[0].stamp;
                    n_idx    = WAY_W'(1);
                    n_state  = (w_nw == WCNT_W'(1)) ? S_EVICT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_age > r_best) begin
                    n_best   = w_age;
                    n_victim = r_idx;
                end
                if (WCNT_W'(r_idx) == w_nw - WCNT_W'(1)) begin
                    n_state = S_EVICT;
                end else begin
                    n_idx = r_idx + WAY_W'(1);
                end
            end
            S_EVICT: begin
                w_wrow = w_rdata;
                w_wrow[r_victim] = '{vld: 1'b1, tag: r_tag, stamp: r_clock};
                w_ram_we  = 1'b1;
                w_fin     = 1'b1;
                w_fin_out = OUT_EVICT;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_done    = 1'b0;
        n_outcome = r_outcome;
        n_extra   = r_extra;
        n_clock   = r_clock;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_evicts  = r_evicts;
        if (w_accept && (t_cmd'(i_cmd) == CMD_FETCH)) begin
            n_done    = 1'b1;
            n_outcome = OUT_IGNORED;
            n_extra   = 1'b0;
        end else if (w_fin) begin
            n_done    = 1'b1;
            n_outcome = w_fin_out;
            n_extra   = r_modify;
            n_clock   = r_clock + STAMP_W'(1);
            n_hits    = sat_add(r_hits, {1'b0, w_fin_out == OUT_HIT} + {1'b0, r_modify});
            n_misses  = sat_add(r_misses, {1'b0, w_fin_out != OUT_HIT});
            n_evicts  = sat_add(r_evicts, {1'b0, w_fin_out == OUT_EVICT});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_set_bits   <= SETB_W'(4);
            r_block_bits <= BLKB_W'(4);
            r_ways       <= WAYSR_W'(1);
            r_row_vld    <= '0;
            r_clock      <= STAMP_W'(1);
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clock  <= n_clock;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
            r_done   <= n_done;
            if (w_ram_we) begin
                r_row_vld[r_set] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SETB_W-1:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                    CFG_WAYS:       r_ways       <= i_cfg_data[WAYSR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_outcome <= n_outcome;
        r_extra   <= n_extra;
        r_idx     <= n_idx;
        r_victim  <= n_victim;
        r_best    <= n_best;
        if (w_accept) begin
            r_set    <= w_set;
            r_tag    <= w_tag;
            r_modify <= (t_cmd'(i_cmd) == CMD_MODIFY);
        end
    end

    assign o_done           = r_done;
    assign o_outcome        = r_outcome;
    assign o_extra_hit      = r_extra;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

endmodule

// ===== sv/lcl_checker.sv =====
// Port-level assertions for the LRU cache lookup block, bound to the top level.
module lcl_checker
    import lcl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [CMD_W-1:0]  i_cmd,
    input logic              o_done,
    input logic [OUT_W-1:0]  o_outcome,
    input logic              o_extra_hit,
    input logic [CNT_W-1:0]  o_hit_total
);

    a_fetch_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_FETCH) |=> (o_done && o_outcome == OUT_IGNORED))
        else $error("fetch word not answered as ignored next cycle");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != CMD_FETCH) |=> (busy && !o_done))
        else $error("lookup word did not hold busy");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_done)
        else $error("result without a word in flight");

    a_ignored_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_outcome == OUT_IGNORED) |-> !o_extra_hit)
        else $error("extra hit on ignored word");

    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_hit_total >= $past(o_hit_total)))
        else $error("hit total went down");

endmodule

bind lru_cache_lookup_unit lcl_checker u_lcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_done      (o_done),
    .o_outcome   (o_outcome),
    .o_extra_hit (o_extra_hit),
    .o_hit_total (o_hit_total)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the LRU cache lookup unit: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import lcl_pkg::*;

    localparam int SETS         = 64;
    localparam int SET_WAYS     = 8;
    localparam int LINES        = SETS * SET_WAYS;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 55;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic     on;
        t_outcome outcome;
        logic     extra;
    } t_pin;

    typedef struct packed {
        t_outcome         outcome;
        logic             extra;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
    } t_result;

    typedef struct packed {
        logic                 is_reg;
        t_cfg_idx             reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
        t_cmd                 cmd;
        logic [ADDR_W-1:0]    addr;
        t_pin                 pin;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 o_done;
    logic [OUT_W-1:0]     o_outcome;
    logic                 o_extra_hit;
    logic [CNT_W-1:0]     o_hit_total;
    logic [CNT_W-1:0]     o_miss_total;
    logic [CNT_W-1:0]     o_eviction_total;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    t_pin                 pin_drv = '0;

    logic              way_valid [LINES];
    logic [TAG_W-1:0]  way_tag [LINES];
    logic [STAMP_W-1:0] way_stamp [LINES];
    logic [STAMP_W-1:0] access_tick;
    logic [CNT_W-1:0]  hit_cnt, miss_cnt, evict_cnt;
    logic [SETB_W-1:0] cfg_set_bits;
    logic [BLKB_W-1:0] cfg_block_bits;
    logic [WAYSR_W-1:0] cfg_ways;

    t_result           pending_results [$];
    t_row              stim_rows [$];
    logic [ADDR_W-1:0] addr_pool [$];
    int                mismatches = 0;
    int                stall_cycles = 0;

    lru_cache_lookup_unit #(
        .MAX_SETS(SETS),
        .MAX_WAYS(SET_WAYS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_address       (i_address),
        .o_done          (o_done),
        .o_outcome       (o_outcome),
        .o_extra_hit     (o_extra_hit),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .o_eviction_total(o_eviction_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic int clamp_ways(input logic [WAYSR_W-1:0] w);
        if (w == 0) return 1;
        if (w > SET_WAYS) return SET_WAYS;
        return int'(w);
    endfunction

    function automatic void clear_cache_model();
        for (int i = 0; i < LINES; i++) begin
            way_valid[i] = 1'b0;
            way_tag[i]   = '0;
            way_stamp[i] = '0;
        end
        access_tick    = 1;
        hit_cnt        = '0;
        miss_cnt       = '0;
        evict_cnt      = '0;
        cfg_set_bits   = 4;
        cfg_block_bits = 4;
        cfg_ways       = 1;
    endfunction

    // LRU lookup of one access; updates the line store and running totals
    function automatic t_result lookup_access(input t_cmd c, input logic [ADDR_W-1:0] a);
        t_result            r;
        logic [31:0]        set_idx;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] age, best_age;
        int                 split, nw, base, hit_w, free_w, victim;
        r.outcome = OUT_IGNORED;
        r.extra   = 1'b0;
        if (c != CMD_FETCH) begin
            split   = int'(cfg_block_bits) + int'(cfg_set_bits);
            set_idx = (a >> cfg_block_bits) & ((32'd1 << cfg_set_bits) - 32'd1);
            set_idx = set_idx % SETS;
            tag     = (split >= 32) ? '0 : (a & (32'hFFFF_FFFF << split));
            nw      = clamp_ways(cfg_ways);
            base    = int'(set_idx) * SET_WAYS;
            hit_w   = -1;
            free_w  = -1;
            for (int w = 0; w < nw; w++) begin
                if (hit_w < 0) begin
                    if (way_valid[base+w] && way_tag[base+w] == tag)
                        hit_w = w;
                    else if (!way_valid[base+w] && free_w < 0)
                        free_w = w;
                end
            end
            if (hit_w >= 0) begin
                way_stamp[base+hit_w] = access_tick;
                hit_cnt   = bump_sat(hit_cnt);
                r.outcome = OUT_HIT;
            end else if (free_w >= 0) begin
                way_valid[base+free_w] = 1'b1;
                way_tag[base+free_w]   = tag;
                way_stamp[base+free_w] = access_tick;
                miss_cnt  = bump_sat(miss_cnt);
                r.outcome = OUT_MISS;
            end else begin
                victim   = 0;
                best_age = '0;
                for (int w = 0; w < nw; w++) begin
                    age = access_tick - way_stamp[base+w];
                    if (w == 0 || age > best_age) begin
                        best_age = age;
                        victim   = w;
                    end
                end
                way_tag[base+victim]   = tag;
                way_stamp[base+victim] = access_tick;
                miss_cnt  = bump_sat(miss_cnt);
                evict_cnt = bump_sat(evict_cnt);
                r.outcome = OUT_EVICT;
            end
            if (c == CMD_MODIFY) begin
                hit_cnt = bump_sat(hit_cnt);
                r.extra = 1'b1;
            end
            access_tick = access_tick + 1'b1;
        end
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        r.evicts = evict_cnt;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result got, want;
        if (!i_rst_n) begin
            clear_cache_model();
        end else begin
            if (o_done) begin
                got.outcome = t_outcome'(o_outcome);
                got.extra   = o_extra_hit;
                got.hits    = o_hit_total;
                got.misses  = o_miss_total;
                got.evicts  = o_eviction_total;
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("result word with nothing expected: outcome %0d",
                                           got.outcome));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"mismatch: exp out %0d x %0d h %0d m %0d e %0d",
                            " / got out %0d x %0d h %0d m %0d e %0d"},
                            want.outcome, want.extra, want.hits, want.misses, want.evicts,
                            got.outcome, got.extra, got.hits, got.misses, got.evicts));
                end
            end
            if (start && !busy) begin
                want = lookup_access(t_cmd'(i_cmd), i_address);
                if (pin_drv.on) begin
                    want.outcome = pin_drv.outcome;
                    want.extra   = pin_drv.extra;
                end
                pending_results.push_back(want);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SET_BITS:   cfg_set_bits   = i_cfg_data[SETB_W-1:0];
                    CFG_BLOCK_BITS: cfg_block_bits = i_cfg_data[BLKB_W-1:0];
                    CFG_WAYS:       cfg_ways       = i_cfg_data[WAYSR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("lru_cache_lookup_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // called just after posedge i_clk; drives the word, then waits until busy is low before returning
    task automatic send_word(input t_cmd c, input logic [ADDR_W-1:0] a, input t_pin p,
                             input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= c;
        i_address <= a;
        pin_drv   <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic void add_word(input t_cmd c, input logic [ADDR_W-1:0] a,
                                     input logic pinned, input t_outcome o, input logic x);
        t_row r;
        r         = '0;
        r.cmd     = c;
        r.addr    = a;
        r.pin.on  = pinned;
        r.pin.outcome = o;
        r.pin.extra   = x;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        t_row r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        stim_rows.push_back(r);
    endfunction

    initial begin
        int                sb, bb, wy, nw, pool_n, set_span, words, gap;
        logic              idle_on, last_phase;
        logic [63:0]       low_mask, blk_mask;
        logic [ADDR_W-1:0] a;
        t_cmd              c;

        // reset config: 4 set bits, 4 block bits, one way
        add_word(CMD_FETCH,  32'h0000_0000, 1, OUT_IGNORED, 0);
        add_word(CMD_LOAD,   32'h0000_0000, 1, OUT_MISS,    0);
        add_word(CMD_LOAD,   32'h0000_000F, 1, OUT_HIT,     0);
        add_word(CMD_STORE,  32'h0000_0000, 1, OUT_HIT,     0);
        add_word(CMD_MODIFY, 32'h0000_0000, 1, OUT_HIT,     1);
        add_word(CMD_LOAD,   32'h0000_0100, 1, OUT_EVICT,   0);
        add_word(CMD_MODIFY, 32'h0000_0000, 1, OUT_EVICT,   1);
        add_word(CMD_LOAD,   32'hFFFF_FFFF, 1, OUT_MISS,    0);
        add_word(CMD_STORE,  32'hFFFF_FFFF, 1, OUT_HIT,     0);
        add_word(CMD_FETCH,  32'hFFFF_FFFF, 1, OUT_IGNORED, 0);
        add_word(CMD_MODIFY, 32'hAAAA_AAAA, 1, OUT_MISS,    1);
        add_word(CMD_LOAD,   32'h5555_5555, 1, OUT_MISS,    0);
        // zero ways acts as one
        add_reg(CFG_WAYS, 0);
        add_word(CMD_LOAD,   32'h0000_0200, 1, OUT_EVICT,   0);
        // oversized ways clamp to eight
        add_reg(CFG_WAYS, 15);
        add_word(CMD_LOAD,   32'h0000_0000, 1, OUT_MISS,    0);
        // split wider than the address: tag is zero
        add_reg(CFG_SET_BITS, 7);
        add_reg(CFG_BLOCK_BITS, 31);
        add_word(CMD_LOAD,   32'h8000_0000, 1, OUT_MISS,    0);
        add_word(CMD_LOAD,   32'h0000_0000, 1, OUT_HIT,     0);
        add_reg(CFG_NONE, 31);
        add_word(CMD_MODIFY, 32'h7FFF_FFFF, 1, OUT_HIT,     1);
        // set index past the last set wraps
        add_reg(CFG_BLOCK_BITS, 0);
        add_word(CMD_LOAD,   32'h0000_007F, 1, OUT_MISS,    0);
        add_word(CMD_LOAD,   32'h0000_003F, 1, OUT_HIT,     0);
        add_reg(CFG_BLOCK_BITS, 16);
        add_reg(CFG_SET_BITS, 6);
        add_reg(CFG_WAYS, 8);
        add_word(CMD_LOAD,   32'hFFFF_0000, 1, OUT_MISS,    0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_reg) begin
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                send_word(stim_rows[i].cmd, stim_rows[i].addr, stim_rows[i].pin, gap);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin sb = 0; bb = 0;  wy = 1;  end
                1: begin sb = 6; bb = 16; wy = 8;  end
                2: begin sb = 7; bb = 31; wy = 15; end
                3: begin sb = 1; bb = 2;  wy = 0;  end
                4: begin sb = 2; bb = 5;  wy = 4;  end
                5: begin sb = 0; bb = 16; wy = 2;  end
                default: begin
                    sb = $urandom_range(0, 7);
                    bb = $urandom_range(0, 31);
                    wy = $urandom_range(0, 15);
                end
            endcase
            write_reg(CFG_SET_BITS, CFG_DAT_W'(sb));
            write_reg(CFG_BLOCK_BITS, CFG_DAT_W'(bb));
            write_reg(CFG_WAYS, CFG_DAT_W'(wy));

            // a few sets, more pool addresses than ways, so hits and evictions can both occur
            nw       = clamp_ways(WAYSR_W'(wy));
            low_mask = (sb + bb >= 32) ? 64'hFFFF_FFFF : (64'd1 << (sb + bb)) - 1;
            blk_mask = (64'd1 << bb) - 1;
            set_span = $urandom_range(0, 3);
            pool_n   = $urandom_range(nw + 1, 3 * nw + 2);
            addr_pool.delete();
            for (int k = 0; k < pool_n; k++) begin
                a = $urandom & ~low_mask[31:0];
                a = a | ADDR_W'((64'($urandom_range(0, set_span)) << bb)
                                & low_mask & ~blk_mask);
                addr_pool.push_back(a);
            end

            last_phase = (ph == PHASES - 1);
            idle_on    = !last_phase && ($urandom_range(0, 3) != 0);
            words      = 0;
            while (words < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0)
                    c = CMD_FETCH;
                else
                    c = t_cmd'($urandom_range(0, 2));
                if ($urandom_range(0, 99) < 15)
                    a = $urandom;
                else
                    a = addr_pool[$urandom_range(0, pool_n - 1)] | ($urandom & blk_mask[31:0]);
                gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                if (!last_phase && $urandom_range(0, 99) == 0)
                    drain_results();
                send_word(c, a, '0, gap);
                words++;
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("lru_cache_lookup_unit test passed");
        else
            $display("lru_cache_lookup_unit test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lcl_pkg.sv
sv/lcl_ram.sv
sv/lcl_addr_split.sv
sv/lru_cache_lookup_unit.sv
sv/lcl_checker.sv
verif/tb_top.sv
